/* rtl/core/dwmd_pkg.sv */
`default_nettype none

package dwmd_pkg;

  // Window and counter sizing
  localparam int MAX_WINDOW = 14;
  localparam int COUNT_BITS = 20;
  localparam int TAPS       = MAX_WINDOW - 1;
  localparam int RUN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int WP_BITS    = $clog2(MAX_WINDOW);

  // Fixed field widths
  localparam int SYM_BITS  = 8;
  localparam int NUM_SYMS  = 1 << SYM_BITS;
  localparam int WIN_BITS  = 4;
  localparam int POS_BITS  = 20;
  localparam int STAT_BITS = 2;

  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(4);
  localparam logic [POS_BITS-1:0] POS_MAX   = '1;

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_SEARCH = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_HIT    = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_DONE   = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_NONE   = 2'd3;

  typedef logic [SYM_BITS-1:0] sym_t;
  typedef logic [WP_BITS-1:0]  wpos_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [POS_BITS-1:0]  position;
  } out_item_t;

  // Write into the last-position memory
  typedef struct packed {
    logic  en;
    sym_t  addr;
    wpos_t pos;
  } lp_wr_t;

  // Registered answer of the last-position memory
  typedef struct packed {
    logic  seen;
    wpos_t pos;
  } lp_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/dwmd_lastpos.sv */
`default_nettype none

// Last-position memory: for each symbol value, the wrapped stream position of
// its most recent occurrence. One read and one write port, registered read,
// bypass when the read hits the entry written at the same edge.
module dwmd_lastpos
  import dwmd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    rd_en,
  input  wire sym_t    rd_addr,
  input  wire lp_wr_t  wr,
  output lp_rsp_t      rsp
);

  wpos_t               lastpos_mem [NUM_SYMS];
  logic [NUM_SYMS-1:0] seen_r;
  wpos_t               rd_pos_r;
  logic                rd_seen_r;
  logic                fwd;

  assign fwd = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lastpos_mem[wr.addr] <= wr.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pos_r <= fwd ? wr.pos : lastpos_mem[rd_addr];
    end
  end

  // Mark entries once written so that an untouched entry never feeds the match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      rd_seen_r <= 1'b0;
    end else begin
      if (wr.en) begin
        seen_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_seen_r <= fwd || seen_r[rd_addr];
      end
    end
  end

  assign rsp.seen = rd_seen_r;
  assign rsp.pos  = rd_pos_r;

endmodule

`default_nettype wire

/* rtl/core/distinct_window_marker_detector.sv */
`default_nettype none

// Distinct-window marker detector. Each item carries one byte of a stream and
// yields exactly one result item: a status (searching, marker completed here,
// marker found earlier, stream ended without marker) and the saturating
// 1-based position of that byte in its stream. A marker is the first place
// where the last window_size bytes are all different; window_size is taken
// from the cfg port (0 acts as 1, values above 14 act as 14) and may only be
// changed between items. An item with end_of_stream set closes the stream and
// restarts the search for the next one. Throughput is one item per clock
// cycle while out_ready does not stall the output; an item passes the stage 1
// and output registers in turn. The last-position memory is read once when an
// item is accepted and written once when it is processed, with a bypass for
// back-to-back repeats of the same byte. No clearing pass is needed after
// reset: the memory's entries carry written flags that reset clears at once.
module distinct_window_marker_detector
  import dwmd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  // result items
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [WIN_BITS-1:0] cfg_wdata
);

  // Configuration
  logic [WIN_BITS-1:0]   window_size_r;

  // Processing stage
  logic                  s1_valid_r, s1_valid_nxt;
  in_item_t              s1_item_r;
  logic                  s1_adv;
  logic                  in_acc;

  // Stream state
  sym_t                  taps_r [TAPS];
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_inc;
  logic [RUN_BITS-1:0]   run_r, run_nxt, run_inc, run_new, w_eff;
  logic                  found_r, found_nxt;
  wpos_t                 wp_r;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  // Memory interface
  lp_wr_t                lp_wr;
  lp_rsp_t               lp_rsp;

  // Match logic
  wpos_t                 lag;
  logic                  tap_match;
  logic                  repeat_hit;
  logic [STAT_BITS-1:0]  status;
  logic [POS_BITS-1:0]   position;
  out_item_t             res;

  // Handshakes: stage 1 moves on whenever the output register is free or
  // being emptied; a new item enters while stage 1 is empty or moving on.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Last-position memory: read at acceptance, write when stage 1 advances.
  assign lp_wr.en   = s1_adv;
  assign lp_wr.addr = s1_item_r.symbol;
  assign lp_wr.pos  = wp_r;

  dwmd_lastpos u_lastpos (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_data.symbol),
    .wr      (lp_wr),
    .rsp     (lp_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_RESET;
    end else if (cfg_we) begin
      window_size_r <= cfg_wdata;
    end
  end

  // Clamp the window to 1..MAX_WINDOW
  always_comb begin
    if (window_size_r == '0) begin
      w_eff = RUN_BITS'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      w_eff = RUN_BITS'(MAX_WINDOW);
    end else begin
      w_eff = RUN_BITS'(window_size_r);
    end
  end

  // Distance back to the previous occurrence of this byte. The memory keeps
  // the latest occurrence ever; confirm it against the shift line so that a
  // stale entry from an older stream or a wrapped position never counts.
  assign lag = wp_r - lp_rsp.pos;

  always_comb begin
    tap_match = 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      if ((lag == WP_BITS'(i + 1)) && (taps_r[i] == s1_item_r.symbol)) begin
        tap_match = 1'b1;
      end
    end
  end

  assign repeat_hit = lp_rsp.seen && tap_match && (32'(lag) <= 32'(count_r));

  // Length of the all-distinct run ending at this byte, held at MAX_WINDOW
  assign run_inc = (32'(run_r) >= MAX_WINDOW) ? run_r : RUN_BITS'(run_r + 1'b1);

  always_comb begin
    if (repeat_hit && (RUN_BITS'(lag) < run_inc)) begin
      run_new = RUN_BITS'(lag);
    end else begin
      run_new = run_inc;
    end
  end

  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  always_comb begin
    if (found_r) begin
      status = ST_DONE;
    end else if (run_new >= w_eff) begin
      status = ST_HIT;
    end else begin
      status = ST_SEARCH;
    end
    if (s1_item_r.end_of_stream && (status == ST_SEARCH)) begin
      status = ST_NONE;
    end
  end

  assign position = (32'(count_inc) > 32'(POS_MAX)) ? POS_MAX : POS_BITS'(count_inc);

  assign res.status   = status;
  assign res.position = position;

  // Stream state: advance on each processed item, drop it all at stream end
  always_comb begin
    count_nxt = count_r;
    run_nxt   = run_r;
    found_nxt = found_r;
    if (s1_adv) begin
      if (s1_item_r.end_of_stream) begin
        count_nxt = '0;
        run_nxt   = '0;
        found_nxt = 1'b0;
      end else begin
        count_nxt = count_inc;
        run_nxt   = run_new;
        found_nxt = found_r || (status == ST_HIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      run_r   <= '0;
      found_r <= 1'b0;
      wp_r    <= '0;
    end else begin
      count_r <= count_nxt;
      run_r   <= run_nxt;
      found_r <= found_nxt;
      if (s1_adv) begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  // Shift line of previous bytes; entries beyond the stream count are ignored
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      taps_r[0] <= s1_item_r.symbol;
      for (int i = 1; i < TAPS; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  // Stage 1 holds the item for its memory read and until the output takes it
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // The run of distinct bytes never outgrows the bytes seen in this stream
  a_run_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_r) <= 32'(count_r))
    else $error("distinct run longer than stream count");

  // A found marker implies at least one byte in the stream
  a_found_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (count_r != '0))
    else $error("marker flagged on empty stream");

  // Stream end clears the search state
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.end_of_stream) |=> ((count_r == '0) && (run_r == '0) && !found_r))
    else $error("stream state not cleared after end of stream");

  // A marker completed mid-stream is remembered for the following items
  a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_item_r.end_of_stream && (status == ST_HIT)) |=> found_r)
    else $error("marker hit not recorded");

endmodule

`default_nettype wire

/* sim/tb_distinct_window_marker_detector.sv */
module tb_distinct_window_marker_detector
  import dwmd_pkg::*;
();

  // Generous ceiling on run time.
  localparam int CYCLE_LIMIT   = 200_000;
  // Quiet cycles after the last result before a register write or the end.
  localparam int LATENCY_SLACK = 6;
  // Longest sender gap in cycles before any one item.
  localparam int MAX_GAP       = 12;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [WIN_BITS-1:0] cfg_wdata = '0;

  // Idle rates in percent, changed from one phase of the run to the next.
  int send_idle_pct = 13;
  int recv_idle_pct = 74;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Results owed by the block, oldest first.
  out_item_t pending_results [$];

  // Shadow of the block's stream state and of the window register.
  sym_t                  recent [MAX_WINDOW];
  logic [COUNT_BITS-1:0] seen_count;
  bit                    marker_seen;
  logic [WIN_BITS-1:0]   window_reg = WIN_RESET;

  distinct_window_marker_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL distinct_window_marker_detector");
      $finish;
    end
  end

  // Receiver back-pressure: drop ready in recv_idle_pct of the cycles.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void log_mismatch(input string what);
    if (mismatch_count < 10)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endfunction

  // Return the stream to its post-reset state; the window register is kept.
  function automatic void clear_stream_state();
    foreach (recent[i]) recent[i] = '0;
    seen_count  = '0;
    marker_seen = 1'b0;
  endfunction

  // Shift one symbol into the shadow window and work out the status and
  // position that the block must report for it.
  function automatic out_item_t advance_stream(input in_item_t item);
    out_item_t res;
    int        span;
    bit        distinct;
    // Clamp the window: zero acts as one, anything past the depth as the depth.
    if (window_reg == '0)
      span = 1;
    else if (int'(window_reg) > MAX_WINDOW)
      span = MAX_WINDOW;
    else
      span = int'(window_reg);
    for (int i = MAX_WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = item.symbol;
    // Saturate the count rather than wrap.
    if (seen_count != '1) seen_count = seen_count + 1'b1;
    distinct = 1'b1;
    for (int a = 0; a < span; a++)
      for (int b = a + 1; b < span; b++)
        if (recent[a] == recent[b]) distinct = 1'b0;
    // Once found, a marker stays found for the rest of the stream.
    if (marker_seen) begin
      res.status = ST_DONE;
    end else if (seen_count >= span && distinct) begin
      marker_seen = 1'b1;
      res.status  = ST_HIT;
    end else begin
      res.status = ST_SEARCH;
    end
    if (64'(seen_count) > 64'(POS_MAX))
      res.position = POS_MAX;
    else
      res.position = POS_BITS'(seen_count);
    // Closing symbol: report a miss if nothing was found, then restart.
    if (item.end_of_stream) begin
      if (res.status == ST_SEARCH) res.status = ST_NONE;
      clear_stream_state();
    end
    return res;
  endfunction

  // Offer one item, with a random gap in front, and hold it until taken.
  // Valid is left high on return: whatever follows in the same step sets it
  // exactly once, either for the next item or low for a pause.
  task automatic send_symbol(input sym_t sym, input bit last);
    in_item_t item;
    int       gap;
    item.symbol        = sym;
    item.end_of_stream = last;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_stream(item));
  endtask

  // Hold the sender until every owed result has come back, then let the
  // pipeline settle.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // Write the window register, only ever with the block idle.
  task automatic write_window(input logic [WIN_BITS-1:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    window_reg = value;
    cfg_we <= 1'b0;
  endtask

  // Compare each result with the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result status %0d position %0d",
                               out_data.status, out_data.position));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.position !== want.position)
          log_mismatch($sformatf("status %0d position %0d, wanted status %0d position %0d",
                                 out_data.status, out_data.position,
                                 want.status, want.position));
      end
    end
  end

  // Reset window of four: three short of a marker, the hit, then found-earlier
  // reports up to and including the closing symbol. Field extremes on symbol.
  task automatic test_default_window();
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h7F, 1'b1);
  endtask

  // A stream that never holds a marker closes with the miss status.
  task automatic test_stream_without_marker();
    send_symbol(8'h07, 1'b0);
    send_symbol(8'h07, 1'b0);
    send_symbol(8'h07, 1'b1);
  endtask

  // Window of zero acts as one: the first symbol is a marker, even when it
  // also closes the stream.
  task automatic test_window_floor();
    write_window('0);
    send_symbol(8'hFF, 1'b1);
  endtask

  // Window of fifteen acts as fourteen: no marker before fourteen symbols.
  task automatic test_window_ceiling();
    write_window('1);
    for (int i = 0; i < 13; i++) send_symbol(sym_t'(i), 1'b0);
    send_symbol(8'hFF, 1'b1);
  endtask

  // Shrink the window mid-stream so the next repeat counts as a marker, then
  // widen it to the full depth: the marker must stay found.
  task automatic test_window_change_mid_stream();
    write_window(WIN_BITS'(4));
    repeat (3) send_symbol(8'h05, 1'b0);
    write_window(WIN_BITS'(1));
    send_symbol(8'h05, 1'b0);
    write_window(WIN_BITS'(MAX_WINDOW));
    send_symbol(8'h05, 1'b0);
    send_symbol(8'h05, 1'b1);
  endtask

  // Random streams. Most draw from a narrow alphabet, the rest are raw bytes;
  // about half get a planted run of distinct symbols so markers land at varied
  // places. Window writes fall between streams and now and then mid-stream.
  task automatic test_random_streams(input int item_budget, input int tx_pct,
                                     input int rx_pct);
    int   sent;
    int   len;
    int   alpha;
    int   base;
    int   plant_at;
    bit   wide;
    bit   planted;
    sym_t sym;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(99) < 30) write_window(WIN_BITS'($urandom_range(15)));
      len      = ($urandom_range(9) == 0) ? 1 : $urandom_range(32, 2);
      alpha    = $urandom_range(14, 1);
      base     = $urandom_range(255 - MAX_WINDOW);
      wide     = ($urandom_range(99) < 25);
      planted  = ($urandom_range(99) < 50);
      plant_at = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
        if (planted && i >= plant_at && i < plant_at + MAX_WINDOW)
          sym = sym_t'(base + i - plant_at);
        else if (wide)
          sym = sym_t'($urandom_range(255));
        else
          sym = sym_t'(base + $urandom_range(alpha - 1));
        // Pause the sender until the block has caught up, once per phase
        // for certain and at random besides.
        if (sent == item_budget / 2 || $urandom_range(99) < 2)
          wait_results_drained();
        if (i > 0 && $urandom_range(99) < 3)
          write_window(WIN_BITS'($urandom_range(15)));
        send_symbol(sym, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    clear_stream_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_default_window();
    test_stream_without_marker();
    test_window_floor();
    test_window_ceiling();
    test_window_change_mid_stream();

    test_random_streams(233, 13, 74);
    test_random_streams(233, 74, 13);
    test_random_streams(234, 0, 0);

    wait_results_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS distinct_window_marker_detector");
    end else begin
      $display("FAIL distinct_window_marker_detector");
    end
    $finish;
  end

endmodule
